FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; the macros compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FBHA_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define FBHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FBHA_ASSERT(label, clk, rst_n, expr, msg)
`define FBHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/fbha_pkg.sv
// Shared types and constants of the heap allocator.
// No dependencies.
package fbha_pkg;

    localparam int ADDR_W = 24;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free_f;
    } seg_entry_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic CFG_FIT_MODE   = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    localparam logic [2:0] ALIGN_MASK = 3'h7;
    localparam int         ALIGN_BYTES = 8;

endpackage

FILE: hdl/fbha_seg_mem.sv
// Segment table memory: one write port, one read port, registered read.
// Depends on fbha_pkg.
module fbha_seg_mem
    import fbha_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  seg_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output seg_entry_t    rd_data
);

    seg_entry_t mem [DEPTH];
    seg_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/first_best_fit_heap_allocator.sv
// Heap allocator top level: request sequencer around the segment table.
// Depends on fbha_pkg, fbha_seg_mem and assert_macros.svh.
//
// Usage:
//   Slave channel s_*: one request beat. s_tuser = kind (0 allocate, 1 free),
//   s_tdata = req_size, addr. Master channel m_*: one result beat per request
//   with status, data_offset, heap_size and free_bytes.
//   cfg_we/cfg_index/cfg_data write fit_mode (index 0) or heap_limit (1);
//   write only while the block is idle.
// Operation:
//   The table lives in one synchronous memory. A request walks it with one
//   read per cycle, then shifts entries for a split or merge, writes up to
//   two entries, and walks it again to total free bytes. A free whose
//   address is out of range skips the first walk.
//   One request is in flight at a time; s_tready is high while idle.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and its result waits until the earlier beat is taken.
// Reset: empty heap, fit_mode first fit, heap_limit all ones. Table contents
//   need no clearing, only entries below the segment count are read.
module first_best_fit_heap_allocator
    import fbha_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // req_size[23:0], addr[47:24]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[1:0], data_offset[25:2],
                                   // heap_size[49:26], free_bytes[73:50], zero pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

`include "assert_macros.svh"

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);
    localparam logic [23:0]   HB      = 24'(HEADER_BYTES);
    localparam logic [24:0]   SPLIT_MIN = 25'(HEADER_BYTES + ALIGN_BYTES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FNEXT  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_WR     = 3'd5;
    localparam logic [2:0] S_SUM    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic          kind_reg, kind_next;
    logic [24:0]   rq_reg, rq_next;
    logic [23:0]   addr_reg, addr_next;
    logic          fit_mode_reg;
    logic [23:0]   heap_limit_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [23:0]   heap_end_reg, heap_end_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [CW-1:0] chk_idx_reg, chk_idx_next;
    logic          found_reg, found_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic [24:0]   best_reg, best_next;
    seg_entry_t    ent_reg, ent_next;
    seg_entry_t    prev_reg, prev_next;
    seg_entry_t    nxt_reg, nxt_next;
    logic [1:0]    status_reg, status_next;
    logic [23:0]   offset_reg, offset_next;
    logic          sh_up_reg, sh_up_next;
    logic [CW-1:0] sh_dist_reg, sh_dist_next;
    logic [CW-1:0] sh_left_reg, sh_left_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [CW-1:0] pend_dst_reg, pend_dst_next;
    logic [CW-1:0] wa0_reg, wa0_next, wa1_reg, wa1_next;
    seg_entry_t    wd0_reg, wd0_next, wd1_reg, wd1_next;
    logic [1:0]    nwr_reg, nwr_next;
    logic          wr_sel_reg, wr_sel_next;
    logic [23:0]   acc_reg, acc_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    o_status_reg, o_status_next;
    logic [23:0]   o_offset_reg, o_offset_next;
    logic [23:0]   o_heap_reg, o_heap_next;
    logic [23:0]   o_free_reg, o_free_next;

    logic          mem_wr_en, mem_rd_en;
    logic [CW-1:0] mem_wr_addr, mem_rd_addr;
    seg_entry_t    mem_wr_data, mem_rd_data;

    fbha_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .IW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr[IW-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr[IW-1:0]),
        .rd_data (mem_rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, o_free_reg, o_heap_reg, o_offset_reg, o_status_reg};

    always_comb
    begin
        logic [23:0]   in_req;
        logic [24:0]   diff;
        logic [24:0]   left;
        logic [25:0]   ext;
        logic          fits;
        logic          pfree;
        logic          hasnext;
        logic [CW-1:0] moves;
        seg_entry_t    e;

        in_req  = s_tdata[23:0];
        diff    = '0;
        left    = '0;
        ext     = '0;
        fits    = 1'b0;
        pfree   = 1'b0;
        hasnext = 1'b0;
        moves   = '0;
        e       = mem_rd_data;

        state_next    = state_reg;
        kind_next     = kind_reg;
        rq_next       = rq_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        heap_end_next = heap_end_reg;
        rd_ptr_next   = rd_ptr_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        ent_next      = ent_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        status_next   = status_reg;
        offset_next   = offset_reg;
        sh_up_next    = sh_up_reg;
        sh_dist_next  = sh_dist_reg;
        sh_left_next  = sh_left_reg;
        pend_vld_next = pend_vld_reg;
        pend_dst_next = pend_dst_reg;
        wa0_next      = wa0_reg;
        wa1_next      = wa1_reg;
        wd0_next      = wd0_reg;
        wd1_next      = wd1_reg;
        nwr_next      = nwr_reg;
        wr_sel_next   = wr_sel_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        o_status_next = o_status_reg;
        o_offset_next = o_offset_reg;
        o_heap_next   = o_heap_reg;
        o_free_next   = o_free_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = wd0_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next = s_tuser;
                    addr_next = s_tdata[47:24];
                    if ((in_req[2:0] & ALIGN_MASK) != 3'd0)
                        rq_next = {({1'b0, in_req[23:3]} + 22'd1), 3'b000};
                    else
                        rq_next = {1'b0, in_req};
                    rd_ptr_next  = '0;
                    chk_vld_next = 1'b0;
                    found_next   = 1'b0;
                    best_next    = '0;
                    acc_next     = '0;
                    status_next  = ST_OK;
                    offset_next  = '0;
                    state_next   = S_SCAN;
                    if (s_tuser == KIND_FREE &&
                        (count_reg == '0 || s_tdata[47:24] >= heap_end_reg ||
                         s_tdata[47:24] < HB))
                    begin
                        status_next = ST_BAD_FREE;
                        state_next  = S_SUM;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + ONE_C;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        fits = e.free_f && ({1'b0, e.size} >= rq_reg);
                        diff = {1'b0, e.size} - rq_reg;
                        if (fits && !fit_mode_reg)
                        begin
                            found_next = 1'b1;
                            pick_next  = chk_idx_reg;
                            ent_next   = e;
                            state_next = S_DECIDE;
                        end
                        else if (fits && (!found_reg || diff < best_reg))
                        begin
                            found_next = 1'b1;
                            best_next  = diff;
                            pick_next  = chk_idx_reg;
                            ent_next   = e;
                        end
                    end
                    else
                    begin
                        if (({1'b0, e.start} + {1'b0, HB}) == {1'b0, addr_reg})
                        begin
                            found_next = 1'b1;
                            pick_next  = chk_idx_reg;
                            ent_next   = e;
                            state_next = S_FNEXT;
                        end
                        else
                        begin
                            prev_next = e;
                        end
                    end
                end
                else if (rd_ptr_reg >= count_reg)
                begin
                    rd_ptr_next = '0;
                    if (kind_reg == KIND_FREE)
                    begin
                        status_next = ST_BAD_FREE;
                        state_next  = S_SUM;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_FNEXT:
            begin
                // read of entry k+1 was issued alongside the hit
                nxt_next   = mem_rd_data;
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                nwr_next      = 2'd0;
                wr_sel_next   = 1'b0;
                pend_vld_next = 1'b0;
                sh_up_next    = 1'b0;
                sh_dist_next  = ONE_C;
                if (kind_reg == KIND_ALLOC)
                begin
                    if (found_reg)
                    begin
                        left        = {1'b0, ent_reg.size} - rq_reg;
                        offset_next = ent_reg.start + HB;
                        if (left >= SPLIT_MIN && count_reg < MAX_CNT)
                        begin
                            wa0_next = pick_reg + ONE_C;
                            wd0_next = '{start:  ent_reg.start + HB + rq_reg[23:0],
                                         size:   left[23:0] - HB,
                                         free_f: 1'b1};
                            wa1_next = pick_reg;
                            wd1_next = '{start: ent_reg.start, size: rq_reg[23:0],
                                         free_f: 1'b0};
                            nwr_next    = 2'd2;
                            moves       = count_reg - pick_reg - ONE_C;
                            sh_up_next  = 1'b1;
                            rd_ptr_next = count_reg - ONE_C;
                            count_next  = count_reg + ONE_C;
                        end
                        else
                        begin
                            wa0_next = pick_reg;
                            wd0_next = '{start: ent_reg.start, size: ent_reg.size,
                                         free_f: 1'b0};
                            nwr_next = 2'd1;
                        end
                    end
                    else
                    begin
                        ext = {2'b00, heap_end_reg} + {2'b00, HB} + {1'b0, rq_reg};
                        if (count_reg >= MAX_CNT || ext > {2'b00, heap_limit_reg})
                        begin
                            status_next = ST_NO_SPACE;
                        end
                        else
                        begin
                            wa0_next = count_reg;
                            wd0_next = '{start: heap_end_reg, size: rq_reg[23:0],
                                         free_f: 1'b0};
                            nwr_next      = 2'd1;
                            count_next    = count_reg + ONE_C;
                            offset_next   = heap_end_reg + HB;
                            heap_end_next = ext[23:0];
                        end
                    end
                end
                else
                begin
                    pfree   = (pick_reg != '0) && prev_reg.free_f;
                    hasnext = (pick_reg + ONE_C) < count_reg;
                    if (pfree && hasnext && nxt_reg.free_f)
                    begin
                        wa0_next = pick_reg - ONE_C;
                        wd0_next = '{start:  prev_reg.start,
                                     size:   prev_reg.size + HB + ent_reg.size + HB +
                                             nxt_reg.size,
                                     free_f: 1'b1};
                        nwr_next     = 2'd1;
                        sh_dist_next = TWO_C;
                        moves        = count_reg - pick_reg - TWO_C;
                        rd_ptr_next  = pick_reg + TWO_C;
                        count_next   = count_reg - TWO_C;
                    end
                    else if (pfree && hasnext)
                    begin
                        wa0_next = pick_reg - ONE_C;
                        wd0_next = '{start:  prev_reg.start,
                                     size:   prev_reg.size + HB + ent_reg.size,
                                     free_f: 1'b1};
                        nwr_next    = 2'd1;
                        moves       = count_reg - pick_reg - ONE_C;
                        rd_ptr_next = pick_reg + ONE_C;
                        count_next  = count_reg - ONE_C;
                    end
                    else if (pfree)
                    begin
                        // merged segment is last: give it back
                        heap_end_next = prev_reg.start;
                        count_next    = count_reg - TWO_C;
                    end
                    else if (hasnext && nxt_reg.free_f)
                    begin
                        wa0_next = pick_reg;
                        wd0_next = '{start:  ent_reg.start,
                                     size:   ent_reg.size + HB + nxt_reg.size,
                                     free_f: 1'b1};
                        nwr_next    = 2'd1;
                        moves       = count_reg - pick_reg - TWO_C;
                        rd_ptr_next = pick_reg + TWO_C;
                        count_next  = count_reg - ONE_C;
                    end
                    else if (hasnext)
                    begin
                        wa0_next = pick_reg;
                        wd0_next = '{start: ent_reg.start, size: ent_reg.size,
                                     free_f: 1'b1};
                        nwr_next = 2'd1;
                    end
                    else
                    begin
                        heap_end_next = ent_reg.start;
                        count_next    = count_reg - ONE_C;
                    end
                end
                sh_left_next = moves;
                if (moves != '0)
                    state_next = S_SHIFT;
                else if (nwr_next != 2'd0)
                    state_next = S_WR;
                else
                begin
                    rd_ptr_next  = '0;
                    chk_vld_next = 1'b0;
                    state_next   = S_SUM;
                end
            end

            S_SHIFT:
            begin
                if (pend_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_dst_reg;
                    mem_wr_data = mem_rd_data;
                end
                if (sh_left_reg != '0)
                begin
                    mem_rd_en     = 1'b1;
                    pend_vld_next = 1'b1;
                    sh_left_next  = sh_left_reg - ONE_C;
                    if (sh_up_reg)
                    begin
                        pend_dst_next = rd_ptr_reg + ONE_C;
                        rd_ptr_next   = rd_ptr_reg - ONE_C;
                    end
                    else
                    begin
                        pend_dst_next = rd_ptr_reg - sh_dist_reg;
                        rd_ptr_next   = rd_ptr_reg + ONE_C;
                    end
                end
                else
                begin
                    pend_vld_next = 1'b0;
                    if (!pend_vld_reg)
                        state_next = S_WR;
                end
            end

            S_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = wr_sel_reg ? wa1_reg : wa0_reg;
                mem_wr_data = wr_sel_reg ? wd1_reg : wd0_reg;
                if (!wr_sel_reg && nwr_reg == 2'd2)
                    wr_sel_next = 1'b1;
                else
                begin
                    rd_ptr_next  = '0;
                    chk_vld_next = 1'b0;
                    state_next   = S_SUM;
                end
            end

            S_SUM:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    chk_vld_next = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + ONE_C;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (e.free_f)
                        acc_next = acc_reg + e.size;
                end
                else if (rd_ptr_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_offset_next = offset_reg;
                    o_heap_next   = heap_end_reg;
                    o_free_next   = acc_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fit_mode_reg   <= 1'b0;
            heap_limit_reg <= 24'hFFFFFF;
            count_reg      <= '0;
            heap_end_reg   <= '0;
            rd_ptr_reg     <= '0;
            chk_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            sh_left_reg    <= '0;
            pend_vld_reg   <= 1'b0;
            nwr_reg        <= 2'd0;
            wr_sel_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heap_end_reg <= heap_end_next;
            rd_ptr_reg   <= rd_ptr_next;
            chk_vld_reg  <= chk_vld_next;
            found_reg    <= found_next;
            sh_left_reg  <= sh_left_next;
            pend_vld_reg <= pend_vld_next;
            nwr_reg      <= nwr_next;
            wr_sel_reg   <= wr_sel_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_MODE:   fit_mode_reg   <= cfg_data[0];
                    CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    default:        fit_mode_reg   <= fit_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        rq_reg       <= rq_next;
        addr_reg     <= addr_next;
        chk_idx_reg  <= chk_idx_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        ent_reg      <= ent_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        status_reg   <= status_next;
        offset_reg   <= offset_next;
        sh_up_reg    <= sh_up_next;
        sh_dist_reg  <= sh_dist_next;
        pend_dst_reg <= pend_dst_next;
        wa0_reg      <= wa0_next;
        wa1_reg      <= wa1_next;
        wd0_reg      <= wd0_next;
        wd1_reg      <= wd1_next;
        acc_reg      <= acc_next;
        o_status_reg <= o_status_next;
        o_offset_reg <= o_offset_next;
        o_heap_reg   <= o_heap_next;
        o_free_reg   <= o_free_next;
    end

    `FBHA_ASSERT(a_count_max, clk, rst_n, count_reg <= MAX_CNT, "segment count overflow")
    `FBHA_ASSERT_IMP(a_empty_heap, clk, rst_n, count_reg == '0, heap_end_reg == '0, "empty table with nonzero heap end")
    `FBHA_ASSERT_IMP(a_scan_idx, clk, rst_n, state_reg == S_SCAN && chk_vld_reg, chk_idx_reg < count_reg, "scan checks entry beyond count")
    `FBHA_ASSERT_IMP(a_wr_addr, clk, rst_n, mem_wr_en, mem_wr_addr < MAX_CNT, "table write beyond depth")

endmodule
